// File: src/lrgb_ok_pkg.sv
// ----------------------------------------------------------------------------
// lrgb_ok_pkg: shared constants for the linear RGB to Oklab converter
// Q.28 matrix coefficients, widths, and the cube-root cell step.
// ----------------------------------------------------------------------------
package lrgb_ok_pkg;

  localparam int FracBitsDef = 15;
  localparam int CoefBits    = 28;
  localparam int RootBits    = 20;
  localparam int ChW         = 16;
  // lms20 < 2^21, radicand lms20 << 40 < 2^61; root < 2^21
  localparam int RadW        = 63;
  localparam int YW          = 21;
  localparam int NSteps      = 21;  // digit steps at s=60..0 (s=63 step is always zero)

  localparam logic signed [31:0] M1 [3][3] = '{
    '{32'sd110654858, 32'sd143970669, 32'sd13809929},
    '{32'sd56882412,  32'sd182723893, 32'sd28829151},
    '{32'sd23703512,  32'sd75623325,  32'sd169108620}
  };

  localparam logic signed [31:0] M2 [3][3] = '{
    '{32'sd56493384,  32'sd213035152,  -32'sd1093082},
    '{32'sd530964928, -32'sd651920256, 32'sd120955328},
    '{32'sd6953562,   32'sd210123696,  -32'sd217077248}
  };

  typedef struct packed {
    logic [RadW-1:0] x;
    logic [YW-1:0]   y;
  } cbrt_t;

endpackage

// File: src/linear_rgb_to_oklab_unit.sv
// Throughput 1 beat/clk while the output is not stalled.
// The depth is the 21 cube-root cells plus matrix, multiply, sum and round stages.
// The whole pipe advances together; output stall holds every stage.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab_unit: linear RGB plus alpha to Oklab, pipelined
// Matrix to LMS, cube root by a chain of digit cells, matrix to Lab.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab_unit import lrgb_ok_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // red_lin, green_lin, blue_lin, alpha_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // lightness, axis_a, axis_b, alpha_out
);

  localparam int Depth  = NSteps + 4;
  localparam int Sh1    = FRAC_BITS + CoefBits - RootBits;
  localparam int Sh2    = CoefBits + RootBits - FRAC_BITS;
  localparam longint One = longint'(1) << FRAC_BITS;
  localparam longint LMax = (One > 65535) ? 65535 : One;

  logic [Depth-1:0] vld_q;
  logic             en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  logic [ChW-1:0] alpha_q [Depth];
  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q[0] <= s_axis_tdata[63:48];
      for (int i = 1; i < Depth; i++) alpha_q[i] <= alpha_q[i-1];
    end
  end

  // stage 0: clamp and first-matrix products
  logic signed [63:0] p1_q [3][3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        logic [ChW-1:0] v;
        logic [17:0]    c;
        v = s_axis_tdata[j*ChW +: ChW];
        c = (64'(v) > One) ? 18'(One) : 18'(v);
        for (int i = 0; i < 3; i++) p1_q[i][j] <= 64'(M1[i][j]) * 64'(signed'({1'b0, c}));
      end
    end
  end

  // stage 1: sum, round to Q.20, form radicand
  cbrt_t rad_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [63:0] acc;
        logic [63:0] l20;
        acc = 64'(p1_q[i][0] + p1_q[i][1] + p1_q[i][2]);
        l20 = (acc + (64'(1) << (Sh1 - 1))) >> Sh1;
        rad_q[i].x <= RadW'(l20 << (2 * RootBits));
        rad_q[i].y <= '0;
      end
    end
  end

  cbrt_t chain [NSteps+1][3];
  assign chain[0] = rad_q;
  for (genvar g = 0; g < NSteps; g++) begin : g_cell
    lrgb_ok_cbrt_cell #(.Shift(60 - 3 * g)) u_cell (
      .clk_i, .en_i(en), .st_i(chain[g]), .st_o(chain[g+1])
    );
  end

  // second-matrix products, then sum/round/saturate
  logic signed [63:0] p2_q [3][3];
  logic [ChW-1:0]     res_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p2_q[i][j] <= 64'(M2[i][j]) * 64'(signed'({1'b0, chain[NSteps][j].y}));
      for (int i = 0; i < 3; i++) begin
        logic signed [63:0] acc;
        logic [63:0]        mag;
        logic signed [63:0] r;
        acc = p2_q[i][0] + p2_q[i][1] + p2_q[i][2];
        mag = acc[63] ? 64'(-acc) : 64'(acc);
        mag = (mag + (64'(1) << (Sh2 - 1))) >> Sh2;
        r   = acc[63] ? -signed'(mag) : signed'(mag);
        if (i == 0) res_q[i] <= (r < 0) ? '0 : ((r > LMax) ? ChW'(LMax) : ChW'(r));
        else res_q[i] <= (r < -32768) ? 16'h8000 : ((r > 32767) ? 16'h7fff : ChW'(r));
      end
    end
  end

  assign m_axis_tdata = {alpha_q[Depth-1], res_q[2], res_q[1], res_q[0]};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("out beat lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("stalled while empty");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 64'(m_axis_tdata[15:0]) <= LMax) else $error("L over range");
`endif

endmodule

// File: src/lrgb_ok_cbrt_cell.sv
// ----------------------------------------------------------------------------
// lrgb_ok_cbrt_cell: one registered digit step of the cube root
// Decides one root bit for three lanes and hands the partial state on.
// ----------------------------------------------------------------------------
module lrgb_ok_cbrt_cell import lrgb_ok_pkg::*; #(
  parameter int Shift = 0
) (
  input  logic     clk_i,
  input  logic     en_i,
  input  cbrt_t    st_i [3],
  output cbrt_t    st_o [3]
);

  cbrt_t st_d [3];
  cbrt_t st_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [YW-1:0]   y2;
      logic [YW:0]     y2p1;
      logic [2*YW:0]   sq;
      logic [RadW-1:0] b;
      y2   = {st_i[k].y[YW-2:0], 1'b0};
      y2p1 = {1'b0, y2} + (YW+1)'(1);
      sq   = y2 * y2p1;
      // 3*y*(y+1) + 1
      b    = (RadW'(sq) << 1) + RadW'(sq) + RadW'(1);
      st_d[k].x = st_i[k].x;
      st_d[k].y = y2;
      if ((st_i[k].x >> Shift) >= b) begin
        st_d[k].x = st_i[k].x - (b << Shift);
        st_d[k].y = y2 | YW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: linear RGB to Oklab converter stream check
// Drives pixel beats with random gaps and in a back-to-back run, predicts Oklab
// per pixel in integer fixed point, and compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import lrgb_ok_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int Latency  = 25;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] b;
    logic [15:0] a;
    logic [15:0] l;
  } lab_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  lab_t lab_queue[$];
  int   err_count = 0;
  bit   sink_busy = 1'b1;
  int   sink_wait = 0;

  linear_rgb_to_oklab_unit #(.FRAC_BITS(FracBits)) DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned cube_root(longint unsigned x);
    longint unsigned y, b;
    y = 0;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((x >> s) >= b) begin
        x = x - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint unsigned half;
    half = 64'd1 << (sh - 1);
    if (v >= 0) return longint'((unsigned'(v) + half) >> sh);
    return -longint'((unsigned'(-v) + half) >> sh);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t oklab_of(pixel_t p);
    longint ch[3], root[3], res[3], acc, one, lmax;
    longint unsigned lms20;
    lab_t r;
    one = longint'(1) << FracBits;
    ch[0] = p.red > one ? one : p.red;
    ch[1] = p.green > one ? one : p.green;
    ch[2] = p.blue > one ? one : p.blue;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(M1[i][j]) * ch[j];
      lms20 = (unsigned'(acc) + (64'd1 << (FracBits + CoefBits - RootBits - 1)))
              >> (FracBits + CoefBits - RootBits);
      root[i] = longint'(cube_root(lms20 << (2 * RootBits)));
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(M2[i][j]) * root[j];
      res[i] = round_away(acc, CoefBits + RootBits - FracBits);
    end
    lmax = one > 65535 ? 65535 : one;
    r.l = 16'(sat(res[0], 0, lmax));
    r.a = 16'(sat(res[1], -32768, 32767));
    r.b = 16'(sat(res[2], -32768, 32767));
    r.alpha = p.alpha;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // one beat, random gap ahead of it; valid stays up until the caller drops it
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lab_queue.push_back(oklab_of(p));
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // receiver: after each taken beat, draw a random wait into sink_wait and hold ready low until it runs out
  always @(posedge clk_i) begin
    int n;
    if (sink_busy) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      n = $urandom_range(0, 4);
      sink_wait <= n;
      m_axis_tready <= (n == 0);
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      sink_wait <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    lab_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (lab_queue.size() == 0) begin
        $display("unexpected output beat %h", m_axis_tdata);
        err_count++;
      end else begin
        want = lab_queue.pop_front();
        if (got.l !== want.l) report("lightness", got.l, want.l);
        if (got.a !== want.a) report("axis_a", got.a, want.a);
        if (got.b !== want.b) report("axis_b", got.b, want.b);
        if (got.alpha !== want.alpha) report("alpha_out", got.alpha, want.alpha);
      end
    end
  end

  task automatic test_extremes();
    logic [15:0] v[6] = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32769, 16'hFFFF};
    pixel_t p;
    foreach (v[i]) begin
      p = '{alpha: v[i], blue: v[i], green: v[i], red: v[i]};
      send_pixel(p);
    end
    send_pixel('{alpha: 16'h5555, blue: 0, green: 0, red: 16'd32768});
    send_pixel('{alpha: 16'hAAAA, blue: 0, green: 16'd32768, red: 0});
    send_pixel('{alpha: 16'hFFFF, blue: 16'd32768, green: 0, red: 0});
    send_pixel('{alpha: 16'd0, blue: 16'hFFFF, green: 0, red: 0});
    send_pixel('{alpha: 16'd1, blue: 0, green: 16'hFFFF, red: 16'hFFFF});
    send_pixel('{alpha: 16'h8000, blue: 16'd1, green: 16'd1, red: 16'd32768});
    send_pixel('{alpha: 16'h7FFF, blue: 16'd32768, green: 16'd1, red: 16'd1});
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_drain_pause();
    while (lab_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random(int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p = '{alpha: 16'($urandom), blue: rand_chan(), green: rand_chan(), red: rand_chan()};
      send_pixel(p);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_back_to_back(int n);
    pixel_t p;
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      p = '{alpha: 16'($urandom), blue: rand_chan(), green: rand_chan(), red: rand_chan()};
      s_axis_tdata <= p;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      lab_queue.push_back(oklab_of(p));
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_busy <= 1'b0;
    @(posedge clk_i);
    test_extremes();
    test_drain_pause();
    test_random(450);
    test_drain_pause();
    test_back_to_back(100);
    test_random(350);
    while (lab_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (err_count == 0 && lab_queue.size() == 0)
      $display("linear_rgb_to_oklab_unit verification clean");
    else
      $display("linear_rgb_to_oklab_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("linear_rgb_to_oklab_unit verification failed");
    $finish;
  end

endmodule

// File: files.f
src/lrgb_ok_pkg.sv
src/lrgb_ok_cbrt_cell.sv
src/linear_rgb_to_oklab_unit.sv
bench/testbench.sv
